### design/lbp_pkg.sv
// Package for the LSB-first bit packer: item types, result bundle and fixed widths.
// No dependencies; every other file of the block imports it.
package lbp_pkg;

  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 4;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;
  localparam int WIN_W       = CODE_W + BYTE_W;
  localparam int TOT_W       = 6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic              command;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  // Bytes completed by one item, oldest in entry 0.
  typedef struct packed {
    logic [CNT_W-1:0]                        count;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0]      bytes;
  } calc_res_t;

endpackage

### design/lbp_calc.sv
// Single-pass packing logic: merges one item into the pending byte and lists the
// bytes it completes. Combinational only; depends on lbp_pkg.
module lbp_calc #(
  parameter int UNIT_BITS = 8
) (
  input  lbp_pkg::in_item_t              item,
  input  logic [lbp_pkg::BYTE_W-1:0]     pend,
  input  logic [lbp_pkg::FILL_W-1:0]     fill,
  output lbp_pkg::calc_res_t             res,
  output logic [lbp_pkg::BYTE_W-1:0]     pend_nxt,
  output logic [lbp_pkg::FILL_W-1:0]     fill_nxt
);
  import lbp_pkg::*;

  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] code_m;
  logic [WIN_W-1:0]  win;
  logic [WIN_W-1:0]  win_sh;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  shamt;
  logic [TOT_W-1:0]  rest;
  logic [TOT_W-1:0]  keep;
  logic [CNT_W-1:0]  n_emit;

  always_comb begin
    len_sat = (item.code_length > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : item.code_length;
    for (int i = 0; i < CODE_W; i++) begin
      code_m[i] = item.code_bits[i] & (LEN_W'(i) < len_sat);
    end
    win   = ({{BYTE_W{1'b0}}, code_m} << fill) | {{CODE_W{1'b0}}, pend};
    total = TOT_W'(fill) + TOT_W'(len_sat);

    // A unit goes out only once a later bit lands past it; cap at the port limit.
    n_emit = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      n_emit = n_emit + CNT_W'(total > TOT_W'((k + 1) * UNIT_BITS));
    end

    shamt  = TOT_W'(n_emit) * TOT_W'(UNIT_BITS);
    rest   = total - shamt;
    keep   = (rest > TOT_W'(UNIT_BITS)) ? TOT_W'(UNIT_BITS) : rest;
    win_sh = win >> shamt;

    for (int j = 0; j < BYTE_W; j++) begin
      pend_nxt[j] = win_sh[j] & (TOT_W'(j) < keep);
    end
    fill_nxt = FILL_W'(keep);

    res.count = n_emit;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res.bytes[k] = BYTE_W'(win[k*UNIT_BITS +: UNIT_BITS]);
    end

    if (item.command == CMD_FLUSH) begin
      res.count    = (fill != '0) ? CNT_W'(1) : '0;
      res.bytes[0] = pend;
      pend_nxt     = '0;
      fill_nxt     = '0;
    end
  end

endmodule

### design/lbp_queue.sv
// Result buffer: holds the bytes of one item and hands them out one per cycle while out_stall is low.
// Depends on lbp_pkg.
module lbp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  lbp_pkg::calc_res_t   load_res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lbp_pkg::out_item_t   out_item
);
  import lbp_pkg::*;

  logic                               q_v_r, q_v_nxt;
  logic [CNT_W-1:0]                   q_cnt_r, q_cnt_nxt;
  logic [MAX_RESULTS-1:0][BYTE_W-1:0] q_bytes_r, q_bytes_nxt;
  logic                               pop;

  assign pop  = q_v_r && !out_stall;
  assign free = !q_v_r || (pop && q_cnt_r == CNT_W'(1));

  assign out_valid         = q_v_r;
  assign out_item.out_byte = q_bytes_r[0];
  assign out_item.last     = (q_cnt_r == CNT_W'(1));

  always_comb begin
    q_v_nxt     = q_v_r;
    q_cnt_nxt   = q_cnt_r;
    q_bytes_nxt = q_bytes_r;
    if (load) begin
      q_v_nxt     = 1'b1;
      q_cnt_nxt   = load_res.count;
      q_bytes_nxt = load_res.bytes;
    end else if (pop) begin
      // advance to the next byte
      q_v_nxt   = (q_cnt_r != CNT_W'(1));
      q_cnt_nxt = q_cnt_r - CNT_W'(1);
      for (int k = 0; k < MAX_RESULTS; k++) begin
        q_bytes_nxt[k] = (k < MAX_RESULTS - 1) ? q_bytes_r[(k + 1) % MAX_RESULTS] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r   <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      q_v_r   <= q_v_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
    q_bytes_r <= q_bytes_nxt;
  end

endmodule

### design/lsb_first_bit_packer_core.sv
// LSB-first bit packer top level: input register, packing logic, result buffer.
// Depends on lbp_pkg, lbp_calc and lbp_queue.
//
// Write items append code_length low bits of code_bits (lengths above 32 count as
// 32) to a pending byte, least significant bit first; a full byte leaves only when
// the next bit arrives, and a flush item sends out the pending byte if it holds any
// bit and then clears it. An item is registered, merged in one pass and its
// completed bytes move to the result buffer, which sends one byte per cycle while
// out_stall is low, with last set on the final byte of that item. An accepted item
// passes the input register and then the result buffer before its first byte shows.
// Items with no byte or one byte stream back to back while out_stall is low; an item
// with n bytes (up to 4) holds back the next item with bytes, paced by the single port.
module lsb_first_bit_packer_core #(
  parameter int UNIT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lbp_pkg::out_item_t out_item
);
  import lbp_pkg::*;

  logic                  in_v_r, in_v_nxt;
  in_item_t              in_d_r;
  logic [BYTE_W-1:0]     pend_r, pend_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  calc_res_t             res;
  logic                  q_free;
  logic                  advance;
  logic                  load;
  logic                  accept;

  lbp_calc #(.UNIT_BITS(UNIT_BITS)) u_calc (
    .item     (in_d_r),
    .pend     (pend_r),
    .fill     (fill_r),
    .res      (res),
    .pend_nxt (pend_nxt),
    .fill_nxt (fill_nxt)
  );

  lbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_res  (res),
    .free      (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Items without bytes only update the pending state; they never wait on the buffer.
  assign advance  = in_v_r && (res.count == '0 || q_free);
  assign load     = advance && (res.count != '0);
  assign in_stall = in_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      pend_r <= '0;
      fill_r <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (advance) begin
        pend_r <= pend_nxt;
        fill_r <= fill_nxt;
      end
    end
    if (accept) begin
      in_d_r <= in_item;
    end
  end

endmodule
